// File: src/hlcp_pkg.sv
// ----------------------------------------------------------------------------
// hlcp_pkg
// Shared types and constants of the hop limited cheapest path engine.
// ----------------------------------------------------------------------------
package hlcp_pkg;

   // field widths of the request and response
   localparam int NODE_BITS      = 6;
   localparam int WEIGHT_IN_BITS = 16;
   localparam int LIMIT_BITS     = 6;
   localparam int NC_BITS        = 7;
   localparam int COST_BITS      = 22;
   localparam int ROUND_BITS     = 7;

   // distances grow by at most one weight per round, 64 rounds at most
   localparam int HOP_BITS  = 7;
   // node indices on the request are 6 bits, so 64 nodes can ever be named
   localparam int NODE_SPAN = 64;

   localparam logic [COST_BITS-1:0] COST_MAX = 22'h3FFFFF;
   localparam logic [NC_BITS-1:0]   NC_RESET = 7'd64;

   // request actions
   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_UNREACH = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_RANGE   = 2'd3;

   typedef struct packed {
      logic [1:0]                action;
      logic [NODE_BITS-1:0]      from_node;
      logic [NODE_BITS-1:0]      to_node;
      logic [WEIGHT_IN_BITS-1:0] edge_weight;
      logic [NODE_BITS-1:0]      source_node;
      logic [NODE_BITS-1:0]      dest_node;
      logic [LIMIT_BITS-1:0]     stop_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [COST_BITS-1:0] path_cost;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COPY,
      S_EDGE_RD,
      S_EDGE_LOOK,
      S_EDGE_UPD,
      S_ROUND_END,
      S_FINAL_RD,
      S_FINAL
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic copy_step;
      logic edge_read;
      logic edge_look;
      logic edge_update;
      logic round_end;
      logic final_read;
      logic final_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic query_go;
      logic sweep_last;
      logic edge_none;
      logic edge_last;
      logic round_last;
   } stat_type;

endpackage

// File: src/hop_limited_cheapest_path.sv
// ----------------------------------------------------------------------------
// hop_limited_cheapest_path
// Edge store with hop bounded cheapest path queries.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready with payload req_data; each request
// gets exactly one response on rsp_valid/rsp_ready with payload rsp_data.
// Add edge, clear and rejected requests are answered at once: the response is
// registered the cycle after acceptance and a new request can be taken every
// cycle while the response register drains.
// A query holds the request port for its whole run. With N active nodes,
// E stored edges and stop limit K it runs K+1 rounds: each round is a copy
// sweep of the N entries of the distance bank, then a read, lookup and update
// step per edge through the edge RAM and distance banks.
// csr_write_enable/csr_write_data set node_count, which is registered; write
// it only while no request is in flight.
// Reset (synchronous) empties the edge store, sets node_count to 64 and drops
// any pending response. A stalled receiver holds the response register; one
// further quick request is accepted only as the register is taken.
// ----------------------------------------------------------------------------
module hop_limited_cheapest_path import hlcp_pkg::*; #(
   parameter int MAX_NODES   = 64,
   parameter int MAX_EDGES   = 256,
   parameter int WEIGHT_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_write_enable,
   input  logic [NC_BITS-1:0] csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   hlcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // storage and arithmetic
   hlcp_dpath #(
      .MAX_NODES   (MAX_NODES),
      .MAX_EDGES   (MAX_EDGES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .rsp_ready        (rsp_ready),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data)
   );

endmodule

// File: src/hlcp_ram.sv
// ----------------------------------------------------------------------------
// hlcp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hlcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/hlcp_ctrl.sv
// ----------------------------------------------------------------------------
// hlcp_ctrl
// Sequencer: accepts requests and steps a query through its copy sweeps,
// edge relaxation passes and final lookup.
// ----------------------------------------------------------------------------
module hlcp_ctrl import hlcp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  stat_type stat,
   output logic     req_ready,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && stat.out_free && stat.query_go) begin
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            if (stat.sweep_last) begin
               state_in = stat.edge_none ? S_ROUND_END : S_EDGE_RD;
            end
         end
         S_EDGE_RD:   state_in = S_EDGE_LOOK;
         S_EDGE_LOOK: state_in = S_EDGE_UPD;
         S_EDGE_UPD: begin
            state_in = stat.edge_last ? S_ROUND_END : S_EDGE_RD;
         end
         S_ROUND_END: begin
            state_in = stat.round_last ? S_FINAL_RD : S_COPY;
         end
         S_FINAL_RD:  state_in = S_FINAL;
         S_FINAL: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = stat.out_free;
            cmd.take  = req_valid && stat.out_free;
         end
         S_COPY:      cmd.copy_step   = 1'b1;
         S_EDGE_RD:   cmd.edge_read   = 1'b1;
         S_EDGE_LOOK: cmd.edge_look   = 1'b1;
         S_EDGE_UPD:  cmd.edge_update = 1'b1;
         S_ROUND_END: cmd.round_end   = 1'b1;
         S_FINAL_RD:  cmd.final_read  = 1'b1;
         S_FINAL:     cmd.final_load  = stat.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: src/hlcp_dpath.sv
// ----------------------------------------------------------------------------
// hlcp_dpath
// Datapath: edge store, two distance banks in ping-pong, reached flags,
// counters, relaxation adder and compare, and the response register.
// ----------------------------------------------------------------------------
module hlcp_dpath import hlcp_pkg::*; #(
   parameter int MAX_NODES   = 64,
   parameter int MAX_EDGES   = 256,
   parameter int WEIGHT_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [NC_BITS-1:0] csr_write_data,
   input  req_type            req_data,
   input  cmd_type            cmd,
   input  logic               rsp_ready,
   output stat_type           stat,
   output logic               rsp_valid,
   output rsp_type            rsp_data
);

   localparam int NODE_DEPTH = (MAX_NODES < NODE_SPAN) ? MAX_NODES : NODE_SPAN;
   localparam int NADDR      = $clog2(NODE_DEPTH);
   localparam int EADDR      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECNT       = $clog2(MAX_EDGES + 1);
   localparam int DIST_BITS  = WEIGHT_BITS + HOP_BITS;
   localparam int EDGE_BITS  = 2 * NODE_BITS + WEIGHT_BITS;
   localparam int CMP_BITS   = (DIST_BITS > COST_BITS) ? DIST_BITS : COST_BITS;
   localparam logic [NC_BITS-1:0] NN_LIMIT = NC_BITS'(NODE_DEPTH);
   localparam logic [ECNT-1:0]    EDGE_CAP = ECNT'(MAX_EDGES);

   // control registers
   logic [NC_BITS-1:0]    node_count_ff, node_count_in;
   logic [ECNT-1:0]       edge_total_ff, edge_total_in;
   logic [NADDR-1:0]      idx_ff, idx_in;
   logic                  wr_pend_ff, wr_pend_in;
   logic [NADDR-1:0]      wr_addr_ff, wr_addr_in;
   logic [EADDR-1:0]      eidx_ff, eidx_in;
   logic [ROUND_BITS-1:0] round_ff, round_in;
   logic [NODE_DEPTH-1:0] reach_prev_ff, reach_prev_in;
   logic [NODE_DEPTH-1:0] reach_next_ff, reach_next_in;
   logic                  bank_ff, bank_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [NODE_BITS-1:0]   src_ff, src_in;
   logic [NODE_BITS-1:0]   dst_ff, dst_in;
   logic [LIMIT_BITS-1:0]  limit_ff, limit_in;
   logic [NODE_BITS-1:0]   u_ff, u_in;
   logic [NODE_BITS-1:0]   v_ff, v_in;
   logic [WEIGHT_BITS-1:0] w_ff, w_in;
   rsp_type                rsp_ff, rsp_in;

   logic [NC_BITS-1:0]     nn;
   logic                   add_ok, store_full, query_ok, edge_wr;
   logic [EDGE_BITS-1:0]   edge_wr_data, edge_rd_data;
   logic [NODE_BITS-1:0]   e_from, e_to;
   logic [WEIGHT_BITS-1:0] e_w;
   logic [1:0]             take_status;

   logic                   p_rd_en, p_wr_en, n_rd_en, n_wr_en;
   logic [NADDR-1:0]       p_rd_addr, p_wr_addr, n_rd_addr, n_wr_addr;
   logic [DIST_BITS-1:0]   p_wr_data, n_wr_data, p_rd_data, n_rd_data;
   logic                   b0_rd_en, b0_wr_en, b1_rd_en, b1_wr_en;
   logic [NADDR-1:0]       b0_rd_addr, b0_wr_addr, b1_rd_addr, b1_wr_addr;
   logic [DIST_BITS-1:0]   b0_wr_data, b1_wr_data, b0_rd_data, b1_rd_data;

   logic                   edge_live, upd_write, dst_reached;
   logic [DIST_BITS-1:0]   cand;
   logic [CMP_BITS-1:0]    dist_wide;
   logic [COST_BITS-1:0]   cost_sat;
   logic                   out_free;

   // effective node count, clamped to one and to the node capacity
   always_comb begin
      if (node_count_ff == '0) begin
         nn = NC_BITS'(1);
      end else if (node_count_ff > NN_LIMIT) begin
         nn = NN_LIMIT;
      end else begin
         nn = node_count_ff;
      end
   end

   // request decode
   assign add_ok     = ({1'b0, req_data.from_node} < nn) && ({1'b0, req_data.to_node} < nn);
   assign store_full = edge_total_ff >= EDGE_CAP;
   assign query_ok   = (req_data.action == ACT_QUERY) &&
                       ({1'b0, req_data.source_node} < nn) &&
                       ({1'b0, req_data.dest_node} < nn);
   assign edge_wr    = cmd.take && (req_data.action == ACT_ADD) && add_ok && !store_full;

   always_comb begin
      case (req_data.action)
         ACT_ADD: begin
            if (!add_ok) begin
               take_status = STATUS_RANGE;
            end else if (store_full) begin
               take_status = STATUS_FULL;
            end else begin
               take_status = STATUS_OK;
            end
         end
         ACT_CLEAR: take_status = STATUS_OK;
         ACT_QUERY: take_status = STATUS_RANGE;
         default:   take_status = STATUS_OK;
      endcase
   end

   // edge store
   assign edge_wr_data = {req_data.from_node, req_data.to_node,
                          WEIGHT_BITS'(req_data.edge_weight)};

   hlcp_ram #(
      .WIDTH (EDGE_BITS),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr),
      .wr_addr (edge_total_ff[EADDR-1:0]),
      .wr_data (edge_wr_data),
      .rd_en   (cmd.edge_read),
      .rd_addr (eidx_ff),
      .rd_data (edge_rd_data)
   );

   assign e_from = edge_rd_data[EDGE_BITS-1 -: NODE_BITS];
   assign e_to   = edge_rd_data[WEIGHT_BITS +: NODE_BITS];
   assign e_w    = edge_rd_data[WEIGHT_BITS-1:0];

   // previous-round bank access
   assign p_rd_en   = cmd.copy_step || cmd.edge_look || cmd.final_read;
   assign p_rd_addr = cmd.copy_step ? idx_ff :
                      cmd.edge_look ? e_from[NADDR-1:0] : dst_ff[NADDR-1:0];
   assign p_wr_en   = cmd.take && query_ok;
   assign p_wr_addr = req_data.source_node[NADDR-1:0];
   assign p_wr_data = '0;

   // next-round bank access: copy writeback or relaxed distance
   assign n_rd_en   = cmd.edge_look;
   assign n_rd_addr = e_to[NADDR-1:0];
   assign n_wr_en   = wr_pend_ff || upd_write;
   assign n_wr_addr = wr_pend_ff ? wr_addr_ff : v_ff[NADDR-1:0];
   assign n_wr_data = wr_pend_ff ? p_rd_data : cand;

   // ping-pong mapping of roles onto the two banks
   assign b0_rd_en   = bank_ff ? n_rd_en   : p_rd_en;
   assign b0_rd_addr = bank_ff ? n_rd_addr : p_rd_addr;
   assign b0_wr_en   = bank_ff ? n_wr_en   : p_wr_en;
   assign b0_wr_addr = bank_ff ? n_wr_addr : p_wr_addr;
   assign b0_wr_data = bank_ff ? n_wr_data : p_wr_data;
   assign b1_rd_en   = bank_ff ? p_rd_en   : n_rd_en;
   assign b1_rd_addr = bank_ff ? p_rd_addr : n_rd_addr;
   assign b1_wr_en   = bank_ff ? p_wr_en   : n_wr_en;
   assign b1_wr_addr = bank_ff ? p_wr_addr : n_wr_addr;
   assign b1_wr_data = bank_ff ? p_wr_data : n_wr_data;
   assign p_rd_data  = bank_ff ? b1_rd_data : b0_rd_data;
   assign n_rd_data  = bank_ff ? b0_rd_data : b1_rd_data;

   hlcp_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (NODE_DEPTH)
   ) u_dist0_ram (
      .clock   (clock),
      .wr_en   (b0_wr_en),
      .wr_addr (b0_wr_addr),
      .wr_data (b0_wr_data),
      .rd_en   (b0_rd_en),
      .rd_addr (b0_rd_addr),
      .rd_data (b0_rd_data)
   );

   hlcp_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (NODE_DEPTH)
   ) u_dist1_ram (
      .clock   (clock),
      .wr_en   (b1_wr_en),
      .wr_addr (b1_wr_addr),
      .wr_data (b1_wr_data),
      .rd_en   (b1_rd_en),
      .rd_addr (b1_rd_addr),
      .rd_data (b1_rd_data)
   );

   // relaxation of one edge, skipping edges with stale endpoints or an unreached start
   assign edge_live = ({1'b0, u_ff} < nn) && ({1'b0, v_ff} < nn) &&
                      reach_prev_ff[u_ff[NADDR-1:0]];
   assign cand      = p_rd_data + DIST_BITS'(w_ff);
   assign upd_write = cmd.edge_update && edge_live &&
                      (!reach_next_ff[v_ff[NADDR-1:0]] || (cand < n_rd_data));

   // final lookup with saturation
   assign dst_reached = reach_prev_ff[dst_ff[NADDR-1:0]];
   assign dist_wide   = CMP_BITS'(p_rd_data);
   assign cost_sat    = (dist_wide > CMP_BITS'(COST_MAX)) ? COST_MAX :
                        dist_wide[COST_BITS-1:0];

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next values
   always_comb begin
      node_count_in = node_count_ff;
      edge_total_in = edge_total_ff;
      idx_in        = idx_ff;
      wr_pend_in    = cmd.copy_step;
      wr_addr_in    = idx_ff;
      eidx_in       = eidx_ff;
      round_in      = round_ff;
      reach_prev_in = reach_prev_ff;
      reach_next_in = reach_next_ff;
      bank_in       = bank_ff;
      rsp_valid_in  = rsp_valid_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      limit_in      = limit_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      w_in          = w_ff;
      rsp_in        = rsp_ff;

      if (csr_write_enable) begin
         node_count_in = csr_write_data;
      end

      // accepted request
      if (cmd.take) begin
         idx_in   = '0;
         eidx_in  = '0;
         round_in = '0;
         if (edge_wr) begin
            edge_total_in = edge_total_ff + ECNT'(1);
         end
         if (req_data.action == ACT_CLEAR) begin
            edge_total_in = '0;
         end
         if (query_ok) begin
            src_in        = req_data.source_node;
            dst_in        = req_data.dest_node;
            limit_in      = req_data.stop_limit;
            reach_prev_in = '0;
            reach_prev_in[req_data.source_node[NADDR-1:0]] = 1'b1;
            reach_next_in = reach_prev_in;
         end else begin
            rsp_in.status    = take_status;
            rsp_in.path_cost = '0;
         end
      end

      // sweep and edge counters
      if (cmd.copy_step) begin
         idx_in = idx_ff + NADDR'(1);
      end
      if (cmd.edge_look) begin
         u_in = e_from;
         v_in = e_to;
         w_in = e_w;
      end
      if (cmd.edge_update) begin
         eidx_in = eidx_ff + EADDR'(1);
      end
      if (upd_write) begin
         reach_next_in[v_ff[NADDR-1:0]] = 1'b1;
      end

      // round boundary: next becomes previous
      if (cmd.round_end) begin
         idx_in        = '0;
         eidx_in       = '0;
         round_in      = round_ff + ROUND_BITS'(1);
         reach_prev_in = reach_next_ff;
         bank_in       = !bank_ff;
      end

      if (cmd.final_load) begin
         rsp_in.status    = dst_reached ? STATUS_OK : STATUS_UNREACH;
         rsp_in.path_cost = dst_reached ? cost_sat : '0;
      end

      // response handshake
      if ((cmd.take && !query_ok) || cmd.final_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NC_RESET;
         edge_total_ff <= '0;
         idx_ff        <= '0;
         wr_pend_ff    <= 1'b0;
         wr_addr_ff    <= '0;
         eidx_ff       <= '0;
         round_ff      <= '0;
         reach_prev_ff <= '0;
         reach_next_ff <= '0;
         bank_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         edge_total_ff <= edge_total_in;
         idx_ff        <= idx_in;
         wr_pend_ff    <= wr_pend_in;
         wr_addr_ff    <= wr_addr_in;
         eidx_ff       <= eidx_in;
         round_ff      <= round_in;
         reach_prev_ff <= reach_prev_in;
         reach_next_ff <= reach_next_in;
         bank_ff       <= bank_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff   <= src_in;
      dst_ff   <= dst_in;
      limit_ff <= limit_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      w_ff     <= w_in;
      rsp_ff   <= rsp_in;
   end

   // status to the sequencer
   assign stat.out_free   = out_free;
   assign stat.query_go   = query_ok;
   assign stat.sweep_last = (NC_BITS'(idx_ff) == (nn - NC_BITS'(1)));
   assign stat.edge_none  = (edge_total_ff == '0);
   assign stat.edge_last  = ((ECNT'(eidx_ff) + ECNT'(1)) == edge_total_ff);
   assign stat.round_last = (round_ff == {1'b0, limit_ff});

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // edge count never passes the store capacity
   a_edge_cap: assert property (@(posedge clock) disable iff (reset)
      edge_total_ff <= EDGE_CAP)
      else $error("edge count above capacity");

   // copy writeback and relaxation never share the next-bank write port
   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      !(wr_pend_ff && upd_write))
      else $error("next bank write collision");

   // a new query starts with only the source reached
   a_query_init: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && query_ok) |=> ($onehot(reach_prev_ff) && (reach_prev_ff == reach_next_ff)))
      else $error("query did not start from a single source");

   // the source stays reached through every round
   a_src_kept: assert property (@(posedge clock) disable iff (reset)
      cmd.round_end |-> reach_next_ff[src_ff[NADDR-1:0]])
      else $error("source lost its reached flag");
`endif

endmodule

// File: sim/tb_hop_limited_cheapest_path.sv
// ----------------------------------------------------------------------------
// tb_hop_limited_cheapest_path
// Self-checking bench for the hop limited cheapest path engine: a queue-fed
// request driver and a response monitor compare every response against an
// in-bench hop bounded relaxation of the same edge store, over directed
// corner requests, random graph sets, store overflow and node_count changes.
// ----------------------------------------------------------------------------
module tb_hop_limited_cheapest_path;
   timeunit 1ns;
   timeprecision 1ps;
   import hlcp_pkg::*;

   localparam int          HALF_PERIOD  = 6;
   localparam int          RESET_CYCLES = 8;
   localparam int          EDGE_DEPTH   = 256;
   localparam int          ITEM_TARGET  = 1900;
   localparam int          SETTLE       = 8;
   localparam logic [1:0]  ACT_NONE     = 2'd3;

   // dut signals, known from time zero
   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   req_type            req_data         = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   rsp_type            rsp_data;
   logic               csr_write_enable = 1'b0;
   logic [NC_BITS-1:0] csr_write_data   = '0;

   // bench copy of the edge store and node_count
   logic [NODE_BITS-1:0]      stored_from   [EDGE_DEPTH];
   logic [NODE_BITS-1:0]      stored_to     [EDGE_DEPTH];
   logic [WEIGHT_IN_BITS-1:0] stored_weight [EDGE_DEPTH];
   int unsigned               stored_count = 0;
   logic [NC_BITS-1:0]        node_limit   = NC_RESET;

   req_type     request_backlog [$];
   rsp_type     pending_answers [$];
   rsp_type     answer_due;
   int unsigned items_issued = 0;
   int unsigned mismatches   = 0;
   int unsigned hold_off     = 0;
   int unsigned stall_left   = 0;
   bit          gaps_on      = 1'b0;
   bit          stalls_on    = 1'b0;

   hop_limited_cheapest_path u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // clock
   initial begin
      forever #(HALF_PERIOD) clock = ~clock;
   end

   // node_count as the engine applies it
   function automatic int unsigned active_nodes();
      if (node_limit == 0) return 1;
      if (node_limit > NODE_SPAN) return NODE_SPAN;
      return node_limit;
   endfunction

   // applies one request to the bench store and returns the response it earns
   function automatic rsp_type cheapest_path_result(req_type r);
      rsp_type     res;
      int unsigned nn;
      int unsigned pass_no;
      int unsigned e;
      int unsigned i;
      int unsigned u;
      int unsigned v;
      logic [31:0] cand;
      logic [31:0] total;
      logic [31:0] dist_old [NODE_SPAN];
      logic [31:0] dist_new [NODE_SPAN];
      bit          seen_old [NODE_SPAN];
      bit          seen_new [NODE_SPAN];

      res.status    = STATUS_OK;
      res.path_cost = '0;
      nn = active_nodes();
      case (r.action)
         ACT_ADD: begin
            if (r.from_node >= nn || r.to_node >= nn) begin
               res.status = STATUS_RANGE;
            end else if (stored_count >= EDGE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               stored_from[stored_count]   = r.from_node;
               stored_to[stored_count]     = r.to_node;
               stored_weight[stored_count] = r.edge_weight;
               stored_count++;
            end
         end
         ACT_CLEAR: begin
            stored_count = 0;
         end
         ACT_QUERY: begin
            if (r.source_node >= nn || r.dest_node >= nn) begin
               res.status = STATUS_RANGE;
            end else begin
               for (i = 0; i < NODE_SPAN; i++) begin
                  dist_old[i] = '0;
                  seen_old[i] = 1'b0;
               end
               seen_old[r.source_node] = 1'b1;
               // each round relaxes from the previous round only
               for (pass_no = 0; pass_no <= r.stop_limit; pass_no++) begin
                  dist_new = dist_old;
                  seen_new = seen_old;
                  for (e = 0; e < stored_count; e++) begin
                     u = stored_from[e];
                     v = stored_to[e];
                     if (u < nn && v < nn && seen_old[u]) begin
                        cand = dist_old[u] + stored_weight[e];
                        if (!seen_new[v] || cand < dist_new[v]) begin
                           dist_new[v] = cand;
                           seen_new[v] = 1'b1;
                        end
                     end
                  end
                  dist_old = dist_new;
                  seen_old = seen_new;
               end
               if (!seen_old[r.dest_node]) begin
                  res.status = STATUS_UNREACH;
               end else begin
                  total = dist_old[r.dest_node];
                  if (total > COST_MAX) total = COST_MAX;
                  res.path_cost = total[COST_BITS-1:0];
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned draw_gap();
      int unsigned pick;
      pick = $urandom_range(99, 0);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(3, 1);
      return $urandom_range(24, 4);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         hold_off  <= 0;
      end else begin
         if (req_valid && req_ready)
            pending_answers.insert(pending_answers.size(), cheapest_path_result(req_data));
         if (!req_valid || req_ready) begin
            if (hold_off != 0) begin
               req_valid <= 1'b0;
               hold_off  <= hold_off - 1;
            end else if (request_backlog.size() != 0) begin
               req_data  <= request_backlog.pop_front();
               req_valid <= 1'b1;
               hold_off  <= gaps_on ? draw_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected response, status %0d cost %0d", $time,
                        rsp_data.status, rsp_data.path_cost);
               mismatches++;
            end else begin
               answer_due = pending_answers.pop_front();
               if (rsp_data.status != answer_due.status ||
                   rsp_data.path_cost != answer_due.path_cost) begin
                  $display("%0t: mismatch, expected status %0d cost %0d, got status %0d cost %0d",
                           $time, answer_due.status, answer_due.path_cost,
                           rsp_data.status, rsp_data.path_cost);
                  mismatches++;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (stalls_on && $urandom_range(3, 0) == 0) stall_left <= draw_gap();
         end
      end
   end

   function automatic int unsigned draw_weight();
      int unsigned pick;
      pick = $urandom_range(99, 0);
      if (pick < 40) return $urandom_range(15, 0);
      if (pick < 70) return $urandom_range(255, 0);
      if (pick < 90) return $urandom_range(16'hFFFF, 0);
      return ($urandom_range(1, 0) == 1) ? 16'hFFFF : 0;
   endfunction

   // node index in use, or now and then one at or beyond node_count
   function automatic int unsigned pick_node(int unsigned nn, int unsigned miss_pct);
      if (nn < NODE_SPAN && $urandom_range(99, 0) < miss_pct)
         return $urandom_range(NODE_SPAN - 1, nn);
      return $urandom_range(nn - 1, 0);
   endfunction

   // appends one request to the pending queue
   task automatic append_request(req_type r);
      request_backlog.insert(request_backlog.size(), r);
   endtask

   // unused fields of every request carry random bits
   task automatic push_request(req_type r, logic [1:0] act);
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      r = bits[$bits(req_type)-1:0];
      r.action = act;
      append_request(r);
      if (act != ACT_NONE) items_issued++;
   endtask

   task automatic push_edge(req_type r);
      logic [63:0] bits;
      req_type     full;
      bits = {$urandom, $urandom};
      full = bits[$bits(req_type)-1:0];
      full.action      = ACT_ADD;
      full.from_node   = r.from_node;
      full.to_node     = r.to_node;
      full.edge_weight = r.edge_weight;
      append_request(full);
      items_issued++;
   endtask

   task automatic queue_add(int unsigned from, int unsigned to, int unsigned weight);
      req_type r;
      r             = '0;
      r.from_node   = NODE_BITS'(from);
      r.to_node     = NODE_BITS'(to);
      r.edge_weight = WEIGHT_IN_BITS'(weight);
      push_edge(r);
   endtask

   task automatic queue_query(int unsigned src, int unsigned dst, int unsigned limit);
      logic [63:0] bits;
      req_type     full;
      bits = {$urandom, $urandom};
      full = bits[$bits(req_type)-1:0];
      full.action      = ACT_QUERY;
      full.source_node = NODE_BITS'(src);
      full.dest_node   = NODE_BITS'(dst);
      full.stop_limit  = LIMIT_BITS'(limit);
      append_request(full);
      items_issued++;
   endtask

   // node_count is only written with nothing in flight
   task automatic write_node_count(logic [NC_BITS-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      node_limit        = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // all requests taken and every response back
   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (request_backlog.size() != 0 || req_valid || pending_answers.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one random graph: set node_count, mostly start clean, mix edges and queries
   task automatic graph_phase();
      int unsigned        nn;
      int unsigned        adds_left;
      int unsigned        asks_left;
      int unsigned        edge_guess;
      int unsigned        pick;
      int unsigned        prev_to;
      int unsigned        from;
      int unsigned        limit;
      logic [NC_BITS-1:0] setting;

      pick = $urandom_range(99, 0);
      if (pick < 55)      setting = NC_BITS'($urandom_range(12, 2));
      else if (pick < 80) setting = NC_BITS'($urandom_range(64, 13));
      else if (pick < 85) setting = NC_BITS'(0);
      else if (pick < 88) setting = NC_BITS'(1);
      else if (pick < 92) setting = NC_BITS'(64);
      else if (pick < 95) setting = NC_BITS'(127);
      else                setting = NC_BITS'($urandom_range(127, 65));
      write_node_count(setting);
      nn = active_nodes();
      edge_guess = stored_count;
      // keeping old edges sometimes leaves stale ones beyond node_count
      if (edge_guess > 100 || $urandom_range(9, 0) < 7) begin
         push_request('0, ACT_CLEAR);
         edge_guess = 0;
      end
      adds_left = $urandom_range(30, 2);
      asks_left = $urandom_range(8, 1);
      prev_to   = pick_node(nn, 0);
      while (adds_left + asks_left != 0) begin
         pick = $urandom_range(99, 0);
         if (pick < 3) begin
            push_request('0, ACT_NONE);
         end else if (pick < 5) begin
            push_request('0, ACT_CLEAR);
            edge_guess = 0;
         end else if (adds_left != 0 && (pick < 70 || asks_left == 0)) begin
            // chains give multi-hop paths
            from    = ($urandom_range(99, 0) < 40) ? prev_to : pick_node(nn, 8);
            prev_to = pick_node(nn, 8);
            queue_add(from, prev_to, draw_weight());
            edge_guess++;
            adds_left--;
         end else begin
            // deep hop limits only on small stores to bound query time
            if (edge_guess <= 40 && $urandom_range(9, 0) == 0)
               limit = $urandom_range(63, 0);
            else
               limit = $urandom_range(5, 0);
            queue_query(pick_node(nn, 6), pick_node(nn, 6), limit);
            asks_left--;
         end
      end
   endtask

   // overflow the edge store on a few nodes, then query it
   task automatic fill_store_phase(bit deep);
      int unsigned nn;
      int unsigned i;
      write_node_count(NC_BITS'($urandom_range(8, 3)));
      nn = active_nodes();
      push_request('0, ACT_CLEAR);
      for (i = 0; i < EDGE_DEPTH + 6; i++)
         queue_add(pick_node(nn, 0), pick_node(nn, 0), draw_weight());
      for (i = 0; i < 3; i++)
         queue_query(pick_node(nn, 0), pick_node(nn, 0), $urandom_range(3, 0));
      if (deep) queue_query(0, nn - 1, 63);
   endtask

   // stimulus
   initial begin
      int unsigned phase;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;
      gaps_on   = 1'b1;
      stalls_on = 1'b1;

      // empty store: source to itself, then unreachable with the deepest limit
      queue_query(0, 0, 0);
      queue_query(5, 63, 63);
      // short cheap chain against one expensive direct edge
      queue_add(0, 1, 1);
      queue_add(1, 2, 1);
      queue_add(2, 3, 1);
      queue_add(0, 3, 100);
      queue_add(63, 62, 16'hFFFF);
      queue_add(3, 63, 0);
      queue_query(0, 3, 0);
      queue_query(0, 3, 1);
      queue_query(0, 3, 2);
      queue_query(0, 62, 3);
      queue_query(0, 62, 63);
      queue_query(63, 63, 63);
      push_request('0, ACT_NONE);
      wait_idle();

      // shrink node_count: stale edges skipped, out of range nodes rejected
      write_node_count(NC_BITS'(2));
      queue_query(0, 1, 5);
      queue_add(0, 2, 9);
      queue_query(0, 2, 0);
      queue_query(3, 0, 0);
      wait_idle();

      // zero acts as one node
      write_node_count(NC_BITS'(0));
      queue_add(0, 0, 7);
      queue_query(0, 0, 9);
      queue_query(1, 0, 0);
      wait_idle();

      // above the node span acts as the full span
      write_node_count(NC_BITS'(127));
      queue_query(0, 62, 63);
      push_request('0, ACT_CLEAR);
      queue_query(0, 1, 63);
      wait_idle();

      // random graph sets
      phase = 0;
      while (items_issued < ITEM_TARGET) begin
         gaps_on   = ($urandom_range(3, 0) != 0);
         stalls_on = ($urandom_range(3, 0) != 0);
         if (phase == 8 || phase == 40)
            fill_store_phase(phase == 8);
         else
            graph_phase();
         wait_idle();
         phase++;
      end

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // run limit
   initial begin
      #(200_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule
